// File: hdl/vtp_pkg.sv
package vtp_pkg;

    localparam int TABLE_STAGES = 24;
    localparam int GUARD_SHIFT  = 16;
    localparam int HEADROOM     = 4;
    localparam int ACC_W        = 31;
    localparam int ATAN_W       = 26;
    localparam int ANGLE_W      = 16;
    localparam int OUT_SHIFT    = 13;
    localparam int ROUND_W      = ACC_W - OUT_SHIFT;

    // angles are degrees times 2^20
    localparam logic signed [ACC_W-1:0] DEG_180 = 31'sd188743680;
    localparam logic [ACC_W-1:0] OFFSET_POS = 31'd4096;
    localparam logic [ACC_W-1:0] OFFSET_NEG = 31'd377491456;

    localparam logic [ROUND_W-1:0] FULL_TURN = 18'd46080;
    localparam logic [ANGLE_W-1:0] ANGLE_90  = 16'd11520;
    localparam logic [ANGLE_W-1:0] ANGLE_270 = 16'd34560;

    localparam logic [ATAN_W-1:0] ATAN_Q20 [TABLE_STAGES] = '{
        26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058, 26'd1876857,
        26'd938658,   26'd469357,   26'd234682,   26'd117342,  26'd58671,   26'd29335,
        26'd14668,    26'd7334,     26'd3667,     26'd1833,    26'd917,     26'd458,
        26'd229,      26'd115,      26'd57,       26'd29,      26'd14,      26'd7
    };

    typedef struct packed {
        logic special;
        logic z_pos;
        logic z_neg;
    } flags_t;

    // fold into [0,360), round half up to degrees times 128, wrap a rounded 360
    function automatic logic [ANGLE_W-1:0] to_angle(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-1:0]   sum;
        logic [ROUND_W-1:0] r;
        sum = ACC_W'(acc) + (acc[ACC_W-1] ? OFFSET_NEG : OFFSET_POS);
        r = sum[ACC_W-1:OUT_SHIFT];
        if (r >= FULL_TURN)
        begin
            r = r - FULL_TURN;
        end
        return r[ANGLE_W-1:0];
    endfunction

endpackage

// File: hdl/vector_to_pitch_yaw.sv
// Direction vector to pitch and yaw through two chained CORDIC vectoring pipelines.
// One vector is taken every clock and one result leaves every clock unless the output
// stalls. N = min(CORDIC_STAGES, 24) is the number of unrolled micro-rotations in
// each pass, and the pipe holds one input register, N stages that vector (x, y) for
// yaw while scaling |z| by the same gain, N stages that vector (h, z) for pitch, and
// one output register that folds and rounds. Every stage holds its own valid bit, so
// a stalled output only stops the stages that are full behind it and gaps close up.
// Angles come out as unsigned degrees times 128 in [0, 360); a zero horizontal
// vector gives yaw 0 and pitch 90 (z positive) or 270.
module vector_to_pitch_yaw #(
    parameter int CORDIC_STAGES   = 16,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COMPONENT_WIDTH-1:0]   x_component,
    input  logic signed [COMPONENT_WIDTH-1:0]   y_component,
    input  logic signed [COMPONENT_WIDTH-1:0]   z_component,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [vtp_pkg::ANGLE_W-1:0]         pitch_angle,
    output logic [vtp_pkg::ANGLE_W-1:0]         yaw_angle
);

    localparam int NUM = (CORDIC_STAGES < vtp_pkg::TABLE_STAGES) ?
                         CORDIC_STAGES : vtp_pkg::TABLE_STAGES;
    localparam int W   = COMPONENT_WIDTH + vtp_pkg::GUARD_SHIFT + vtp_pkg::HEADROOM;

    // yaw and gain pass
    logic                             yv   [0:NUM];
    logic                             yst  [0:NUM];
    logic signed [W-1:0]              yx   [0:NUM];
    logic signed [W-1:0]              yy   [0:NUM];
    logic signed [vtp_pkg::ACC_W-1:0] yacc [0:NUM];
    logic signed [W-1:0]              gu   [0:NUM];
    logic signed [W-1:0]              gv   [0:NUM];
    vtp_pkg::flags_t                  yf   [0:NUM];

    // pitch pass
    logic                             pv   [0:NUM];
    logic                             pst  [0:NUM];
    logic signed [W-1:0]              px   [0:NUM];
    logic signed [W-1:0]              py   [0:NUM];
    logic signed [vtp_pkg::ACC_W-1:0] pacc [0:NUM];
    logic signed [vtp_pkg::ACC_W-1:0] pyaw [0:NUM];
    vtp_pkg::flags_t                  pf   [0:NUM];

    vtp_front #(
        .CW (COMPONENT_WIDTH),
        .W  (W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .x_in      (x_component),
        .y_in      (y_component),
        .z_in      (z_component),
        .out_valid (yv[0]),
        .out_stall (yst[0]),
        .x_out     (yx[0]),
        .y_out     (yy[0]),
        .acc_out   (yacc[0]),
        .zm_out    (gu[0]),
        .flags_out (yf[0])
    );

    assign gv[0] = '0;

    genvar i;
    generate
        for (i = 0; i < NUM; i++)
        begin : g_yaw
            vtp_yaw_stage #(
                .W     (W),
                .SHIFT (i)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (yv[i]),
                .in_stall  (yst[i]),
                .x_in      (yx[i]),
                .y_in      (yy[i]),
                .acc_in    (yacc[i]),
                .u_in      (gu[i]),
                .v_in      (gv[i]),
                .flags_in  (yf[i]),
                .out_valid (yv[i+1]),
                .out_stall (yst[i+1]),
                .x_out     (yx[i+1]),
                .y_out     (yy[i+1]),
                .acc_out   (yacc[i+1]),
                .u_out     (gu[i+1]),
                .v_out     (gv[i+1]),
                .flags_out (yf[i+1])
            );
        end
    endgenerate

    // second pass vectors (K*h, K*z), with the sign of z put back
    assign pv[0]    = yv[NUM];
    assign yst[NUM] = pst[0];
    assign px[0]    = yx[NUM];
    assign py[0]    = yf[NUM].z_neg ? -gu[NUM] : gu[NUM];
    assign pacc[0]  = '0;
    assign pyaw[0]  = yacc[NUM];
    assign pf[0]    = yf[NUM];

    generate
        for (i = 0; i < NUM; i++)
        begin : g_pitch
            vtp_pitch_stage #(
                .W     (W),
                .SHIFT (i)
            ) u_stage (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (pv[i]),
                .in_stall  (pst[i]),
                .x_in      (px[i]),
                .y_in      (py[i]),
                .acc_in    (pacc[i]),
                .yaw_in    (pyaw[i]),
                .flags_in  (pf[i]),
                .out_valid (pv[i+1]),
                .out_stall (pst[i+1]),
                .x_out     (px[i+1]),
                .y_out     (py[i+1]),
                .acc_out   (pacc[i+1]),
                .yaw_out   (pyaw[i+1]),
                .flags_out (pf[i+1])
            );
        end
    endgenerate

    vtp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (pv[NUM]),
        .in_stall    (pst[NUM]),
        .pitch_acc   (pacc[NUM]),
        .yaw_acc     (pyaw[NUM]),
        .flags_in    (pf[NUM]),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

    // backpressure only reaches the input when the whole pipe is full and held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held output");

    a_yaw_mag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        yv[NUM] |-> !yx[NUM][W-1])
        else $error("horizontal magnitude negative");

    a_gain_mag_pos: assert property (@(posedge clk) disable iff (!rst_n)
        yv[NUM] |-> !gu[NUM][W-1])
        else $error("scaled vertical magnitude negative");

endmodule

// File: hdl/vtp_front.sv
module vtp_front #(
    parameter int CW = 16,
    parameter int W  = 36
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [CW-1:0]                x_in,
    input  logic signed [CW-1:0]                y_in,
    input  logic signed [CW-1:0]                z_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [W-1:0]                 x_out,
    output logic signed [W-1:0]                 y_out,
    output logic signed [vtp_pkg::ACC_W-1:0]    acc_out,
    output logic signed [W-1:0]                 zm_out,
    output vtp_pkg::flags_t                     flags_out
);

    localparam int EXT = W - CW - vtp_pkg::GUARD_SHIFT;

    logic                             valid_reg;
    logic signed [W-1:0]              x_reg, y_reg, zm_reg;
    logic signed [W-1:0]              x_next, y_next, zm_next;
    logic signed [W-1:0]              xe, ye, ze;
    logic signed [vtp_pkg::ACC_W-1:0] acc_reg, acc_next;
    vtp_pkg::flags_t                  flags_reg, flags_next;

    assign xe = {{EXT{x_in[CW-1]}}, x_in, {vtp_pkg::GUARD_SHIFT{1'b0}}};
    assign ye = {{EXT{y_in[CW-1]}}, y_in, {vtp_pkg::GUARD_SHIFT{1'b0}}};
    assign ze = {{EXT{z_in[CW-1]}}, z_in, {vtp_pkg::GUARD_SHIFT{1'b0}}};

    always_comb
    begin
        // left half plane: turn by 180 first so vectoring converges
        x_next   = x_in[CW-1] ? -xe : xe;
        y_next   = x_in[CW-1] ? -ye : ye;
        acc_next = x_in[CW-1] ? vtp_pkg::DEG_180 : '0;
        zm_next  = z_in[CW-1] ? -ze : ze;
        flags_next.special = (x_in == '0) && (y_in == '0);
        flags_next.z_pos   = !z_in[CW-1] && (z_in != '0);
        flags_next.z_neg   = z_in[CW-1];
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            zm_reg    <= zm_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign acc_out   = acc_reg;
    assign zm_out    = zm_reg;
    assign flags_out = flags_reg;

endmodule

// File: hdl/vtp_yaw_stage.sv
module vtp_yaw_stage #(
    parameter int W     = 36,
    parameter int SHIFT = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [W-1:0]                 x_in,
    input  logic signed [W-1:0]                 y_in,
    input  logic signed [vtp_pkg::ACC_W-1:0]    acc_in,
    input  logic signed [W-1:0]                 u_in,
    input  logic signed [W-1:0]                 v_in,
    input  vtp_pkg::flags_t                     flags_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [W-1:0]                 x_out,
    output logic signed [W-1:0]                 y_out,
    output logic signed [vtp_pkg::ACC_W-1:0]    acc_out,
    output logic signed [W-1:0]                 u_out,
    output logic signed [W-1:0]                 v_out,
    output vtp_pkg::flags_t                     flags_out
);

    localparam logic signed [vtp_pkg::ACC_W-1:0] ATAN_STEP =
        $signed({{(vtp_pkg::ACC_W - vtp_pkg::ATAN_W){1'b0}}, vtp_pkg::ATAN_Q20[SHIFT]});

    logic                             valid_reg;
    logic signed [W-1:0]              x_reg, y_reg, u_reg, v_reg;
    logic signed [W-1:0]              x_next, y_next, u_next, v_next;
    logic signed [W-1:0]              xs, ys, us, vs;
    logic signed [vtp_pkg::ACC_W-1:0] acc_reg, acc_next;
    vtp_pkg::flags_t                  flags_reg;

    assign xs = x_in >>> SHIFT;
    assign ys = y_in >>> SHIFT;
    assign us = u_in >>> SHIFT;
    assign vs = v_in >>> SHIFT;

    // yaw lane drives y to zero; gain lane gives the same CORDIC gain to |z|
    always_comb
    begin
        if (!y_in[W-1])
        begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            acc_next = acc_in + ATAN_STEP;
        end
        else
        begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            acc_next = acc_in - ATAN_STEP;
        end
        if (!v_in[W-1])
        begin
            u_next = u_in + vs;
            v_next = v_in - us;
        end
        else
        begin
            u_next = u_in - vs;
            v_next = v_in + us;
        end
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            u_reg     <= u_next;
            v_reg     <= v_next;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign acc_out   = acc_reg;
    assign u_out     = u_reg;
    assign v_out     = v_reg;
    assign flags_out = flags_reg;

endmodule

// File: hdl/vtp_pitch_stage.sv
module vtp_pitch_stage #(
    parameter int W     = 36,
    parameter int SHIFT = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [W-1:0]                 x_in,
    input  logic signed [W-1:0]                 y_in,
    input  logic signed [vtp_pkg::ACC_W-1:0]    acc_in,
    input  logic signed [vtp_pkg::ACC_W-1:0]    yaw_in,
    input  vtp_pkg::flags_t                     flags_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [W-1:0]                 x_out,
    output logic signed [W-1:0]                 y_out,
    output logic signed [vtp_pkg::ACC_W-1:0]    acc_out,
    output logic signed [vtp_pkg::ACC_W-1:0]    yaw_out,
    output vtp_pkg::flags_t                     flags_out
);

    localparam logic signed [vtp_pkg::ACC_W-1:0] ATAN_STEP =
        $signed({{(vtp_pkg::ACC_W - vtp_pkg::ATAN_W){1'b0}}, vtp_pkg::ATAN_Q20[SHIFT]});

    logic                             valid_reg;
    logic signed [W-1:0]              x_reg, y_reg;
    logic signed [W-1:0]              x_next, y_next;
    logic signed [W-1:0]              xs, ys;
    logic signed [vtp_pkg::ACC_W-1:0] acc_reg, acc_next, yaw_reg;
    vtp_pkg::flags_t                  flags_reg;

    assign xs = x_in >>> SHIFT;
    assign ys = y_in >>> SHIFT;

    always_comb
    begin
        if (!y_in[W-1])
        begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            acc_next = acc_in + ATAN_STEP;
        end
        else
        begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            acc_next = acc_in - ATAN_STEP;
        end
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            acc_reg   <= acc_next;
            yaw_reg   <= yaw_in;
            flags_reg <= flags_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign acc_out   = acc_reg;
    assign yaw_out   = yaw_reg;
    assign flags_out = flags_reg;

endmodule

// File: hdl/vtp_back.sv
module vtp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [vtp_pkg::ACC_W-1:0]    pitch_acc,
    input  logic signed [vtp_pkg::ACC_W-1:0]    yaw_acc,
    input  vtp_pkg::flags_t                     flags_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [vtp_pkg::ANGLE_W-1:0]         pitch_angle,
    output logic [vtp_pkg::ANGLE_W-1:0]         yaw_angle
);

    logic                          valid_reg;
    logic [vtp_pkg::ANGLE_W-1:0]   pitch_reg, yaw_reg;
    logic [vtp_pkg::ANGLE_W-1:0]   pitch_next, yaw_next;

    always_comb
    begin
        if (flags_in.special)
        begin
            // straight up or down: yaw is undefined and reported as zero
            pitch_next = flags_in.z_pos ? vtp_pkg::ANGLE_90 : vtp_pkg::ANGLE_270;
            yaw_next   = '0;
        end
        else
        begin
            pitch_next = vtp_pkg::to_angle(pitch_acc);
            yaw_next   = vtp_pkg::to_angle(yaw_acc);
        end
    end

    assign in_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign out_valid   = valid_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (pitch_reg < 16'd46080) && (yaw_reg < 16'd46080))
        else $error("angle out of range");

endmodule
